// ===== rtl/core/u8u16_pkg.sv =====
// Package for the UTF-8 to UTF-16 decoder: transaction payload types,
// lead byte limits, payload masks and surrogate constants.
// No dependencies.
package u8u16_pkg;

  // One input transaction: a raw UTF-8 byte and the end-of-string mark
  typedef struct packed {
    logic [7:0] byte_in;
    logic       final_byte;
  } byte_item_t;

  // One output transaction: a UTF-16 unit and its end marks
  typedef struct packed {
    logic [15:0] code_unit;
    logic        run_end;
    logic        string_end;
  } unit_item_t;

  // Lead byte classes by magnitude
  localparam logic [7:0] LeadOneLimit   = 8'h80;
  localparam logic [7:0] LeadTwoLimit   = 8'(8'h80 + 8'h40 + 8'h20);
  localparam logic [7:0] LeadThreeLimit = 8'(8'h80 + 8'h40 + 8'h20 + 8'h10);

  // Payload masks
  localparam logic [7:0] ContMask      = 8'h3F;
  localparam logic [7:0] TwoLeadMask   = 8'h1F;
  localparam logic [7:0] ThreeLeadMask = 8'h0F;
  localparam logic [7:0] FourLeadMask  = 8'h07;

  // Surrogate arithmetic: lead = (v >> 10) + 0xD800 - (0x10000 >> 10)
  localparam logic [20:0] PlaneBase    = 21'h10000;
  localparam logic [15:0] HiSurrBase   = 16'hD800;
  localparam logic [15:0] HiSurrOffset = 16'(HiSurrBase - 16'(PlaneBase >> 10));
  localparam logic [5:0]  LoSurrTop    = 6'b110111;

  // Sequence kinds: continuation bytes in the sequence
  localparam logic [1:0] KindNone  = 2'd0;
  localparam logic [1:0] KindTwo   = 2'd1;
  localparam logic [1:0] KindThree = 2'd2;
  localparam logic [1:0] KindFour  = 2'd3;

  // Output buffer depth
  localparam int UnitBufDepth = 4;

endpackage

// ===== rtl/core/utf8_to_utf16_decoder.sv =====
// UTF-8 to UTF-16 decoder top level: byte decode and a small output buffer.
// Depends on u8u16_pkg.
//
// A unit enters the output buffer in the cycle after the byte that completes it.
// Throughput: one byte per cycle unless byte_stall; a four-byte sequence yields a
// surrogate pair, both units pushed together, drained one per cycle unless unit_stall.
// byte_stall is high while fewer than two of the 4 buffer entries are free.
// Reset (rst, synchronous) clears the decoder state and empties the buffer at once.
module utf8_to_utf16_decoder
  import u8u16_pkg::*;
#(
  parameter int Depth = UnitBufDepth
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_stall,
  input  byte_item_t byte_item,
  output logic       unit_valid,
  input  logic       unit_stall,
  output unit_item_t unit_item
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  // Decoder state
  logic [1:0]  bytes_left, bytes_left_next;
  logic [1:0]  seq_kind, seq_kind_next;
  logic [20:0] partial_value, partial_value_next;

  // Output buffer
  unit_item_t            unit_buf [Depth];
  logic [PtrW-1:0]       wr_ptr, rd_ptr;
  logic [CntW-1:0]       count;

  logic       accept, pop;
  logic [1:0] push_cnt;
  unit_item_t w0, w1;
  logic [7:0]  ch;
  logic        fin;
  logic [20:0] cont_bits, merged;
  logic [15:0] hi_unit, lo_unit;

  assign accept     = byte_valid && !byte_stall;
  assign pop        = unit_valid && !unit_stall;
  assign byte_stall = (count > CntW'(Depth - 2));
  assign unit_valid = (count != '0);
  assign unit_item  = unit_buf[rd_ptr];

  assign ch  = byte_item.byte_in;
  assign fin = byte_item.final_byte;

  // Place continuation payload by how many bytes remain
  always_comb begin
    unique case (bytes_left)
      2'd3:    cont_bits = 21'(ch & ContMask) << 12;
      2'd2:    cont_bits = 21'(ch & ContMask) << 6;
      default: cont_bits = 21'(ch & ContMask);
    endcase
  end

  assign merged  = partial_value | cont_bits;
  assign hi_unit = 16'(merged >> 10) + HiSurrOffset;
  assign lo_unit = {LoSurrTop, merged[9:0]};

  // Decode one byte: update state and form up to two units
  always_comb begin
    bytes_left_next    = bytes_left;
    seq_kind_next      = seq_kind;
    partial_value_next = partial_value;
    push_cnt           = 2'd0;
    w0                 = '{code_unit: {8'h00, ch}, run_end: 1'b1, string_end: fin};
    w1                 = '{code_unit: lo_unit, run_end: 1'b1, string_end: fin};
    if (accept) begin
      if (bytes_left == 2'd0) begin
        priority if (ch < LeadOneLimit) begin
          push_cnt = 2'd1;
        end else if (ch < LeadTwoLimit) begin
          partial_value_next = 21'(ch & TwoLeadMask) << 6;
          seq_kind_next      = KindTwo;
          bytes_left_next    = KindTwo;
        end else if (ch < LeadThreeLimit) begin
          partial_value_next = 21'(ch & ThreeLeadMask) << 12;
          seq_kind_next      = KindThree;
          bytes_left_next    = KindThree;
        end else begin
          partial_value_next = 21'(ch & FourLeadMask) << 18;
          seq_kind_next      = KindFour;
          bytes_left_next    = KindFour;
        end
        // Drop a lead cut off by the end of string
        if (fin && ch >= LeadOneLimit) begin
          partial_value_next = '0;
          seq_kind_next      = KindNone;
          bytes_left_next    = 2'd0;
        end
      end else if (bytes_left != 2'd1) begin
        partial_value_next = merged;
        bytes_left_next    = bytes_left - 2'd1;
        if (fin) begin
          partial_value_next = '0;
          seq_kind_next      = KindNone;
          bytes_left_next    = 2'd0;
        end
      end else begin
        // Last continuation: emit unit or surrogate pair, then go idle
        if (seq_kind == KindFour) begin
          w0       = '{code_unit: hi_unit, run_end: 1'b0, string_end: 1'b0};
          push_cnt = 2'd2;
        end else begin
          w0       = '{code_unit: merged[15:0], run_end: 1'b1, string_end: fin};
          push_cnt = 2'd1;
        end
        partial_value_next = '0;
        seq_kind_next      = KindNone;
        bytes_left_next    = 2'd0;
      end
    end
  end

  // Hold decoder state and buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_left    <= 2'd0;
      seq_kind      <= KindNone;
      partial_value <= '0;
      wr_ptr        <= '0;
      rd_ptr        <= '0;
      count         <= '0;
    end else begin
      bytes_left    <= bytes_left_next;
      seq_kind      <= seq_kind_next;
      partial_value <= partial_value_next;
      wr_ptr        <= wr_ptr + PtrW'(push_cnt);
      rd_ptr        <= rd_ptr + PtrW'(pop);
      count         <= count + CntW'(push_cnt) - CntW'(pop);
    end
  end

  // Write buffer entries
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      unit_buf[wr_ptr] <= w0;
    end
    if (push_cnt == 2'd2) begin
      unit_buf[wr_ptr + PtrW'(1)] <= w1;
    end
  end

`ifndef SYNTHESIS
  // Buffer never overfills
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(Depth))
    else $error("unit buffer overfilled");

  // Idle decoder holds no partial sequence
  a_idle_clean: assert property (@(posedge clk) disable iff (rst)
    (bytes_left == 2'd0) |-> (seq_kind == KindNone && partial_value == '0))
    else $error("idle decoder holds stale sequence state");

  // Remaining count never exceeds the sequence length
  a_left_le_kind: assert property (@(posedge clk) disable iff (rst)
    bytes_left <= seq_kind)
    else $error("bytes_left exceeds seq_kind");

  // A lead surrogate always has its trail already buffered behind it
  a_pair_whole: assert property (@(posedge clk) disable iff (rst)
    (unit_valid && !unit_item.run_end) |-> (count >= CntW'(2)))
    else $error("lead surrogate without trail");
`endif

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// Testbench for utf8_to_utf16_decoder: a directed byte table, then random UTF-8 traffic
// with random idling on both sides, checked unit by unit against a local decoder model.
// Depends on u8u16_pkg and the decoder RTL.
module tb_top
  import u8u16_pkg::*;
();

  // Local decode constants
  localparam logic [7:0]  OneByteTop   = 8'h80;
  localparam logic [7:0]  TwoByteTop   = 8'hE0;
  localparam logic [7:0]  ThreeByteTop = 8'hF0;
  localparam logic [15:0] LeadSurrBase = 16'hD800 - 16'h0040;
  localparam logic [15:0] TrailSurrBase = 16'hDC00;
  localparam int          ByteTarget   = 1450;
  localparam int          DirRows      = 25;

  // Directed row: byte, final mark, and a typed expectation where one applies
  typedef struct packed {
    logic [7:0]  b;
    logic        fin;
    logic        typed;
    logic [1:0]  cnt;
    logic [15:0] u0;
    logic [15:0] u1;
  } dir_row_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       byte_valid = 1'b0;
  logic       byte_stall;
  byte_item_t byte_item = '0;
  logic       unit_valid;
  logic       unit_stall = 1'b0;
  unit_item_t unit_item;

  // Decoder model state
  logic [1:0]  pend_cont;
  logic [1:0]  seq_len;
  logic [20:0] acc_bits;

  unit_item_t  unit_q[$];
  dir_row_t    dir_tab [DirRows];
  logic        calm = 1'b0;
  int          err_cnt = 0;
  int          n_bytes = 0;
  int          n_units = 0;
  int          n_pairs = 0;
  int          n_cut = 0;

  utf8_to_utf16_decoder u_dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .byte_item  (byte_item),
    .unit_valid (unit_valid),
    .unit_stall (unit_stall),
    .unit_item  (unit_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic unit_item_t mk_unit(input logic [15:0] code, input logic re,
                                         input logic se);
    unit_item_t u;
    u.code_unit  = code;
    u.run_end    = re;
    u.string_end = se;
    return u;
  endfunction

  task automatic clear_decoder();
    pend_cont = 2'd0;
    seq_len   = KindNone;
    acc_bits  = '0;
  endtask

  // Decode one byte into zero, one or two UTF-16 units
  task automatic decode_byte(input byte_item_t it, output int n,
                             output unit_item_t p0, output unit_item_t p1);
    logic [7:0] b;
    b  = it.byte_in;
    n  = 0;
    p0 = '0;
    p1 = '0;
    if (pend_cont == 2'd0 && b < OneByteTop) begin
      n  = 1;
      p0 = mk_unit({8'h00, b}, 1'b1, it.final_byte);
    end else if (pend_cont == 2'd0) begin
      // Classify the lead by magnitude only
      if (b < TwoByteTop) begin
        acc_bits = 21'(b[4:0]) << 6;
        seq_len  = KindTwo;
      end else if (b < ThreeByteTop) begin
        acc_bits = 21'(b[3:0]) << 12;
        seq_len  = KindThree;
      end else begin
        acc_bits = 21'(b[2:0]) << 18;
        seq_len  = KindFour;
      end
      pend_cont = seq_len;
      if (it.final_byte) begin
        n_cut++;
        clear_decoder();
      end
    end else begin
      // Merge continuation payload, no check of the top bits
      acc_bits  = acc_bits | (21'(b[5:0]) << (6 * (int'(pend_cont) - 1)));
      pend_cont = pend_cont - 2'd1;
      if (pend_cont != 2'd0) begin
        if (it.final_byte) begin
          n_cut++;
          clear_decoder();
        end
      end else begin
        if (seq_len == KindFour) begin
          n  = 2;
          p0 = mk_unit(16'((acc_bits >> 10) + 21'(LeadSurrBase)), 1'b0, 1'b0);
          p1 = mk_unit(TrailSurrBase + 16'(acc_bits[9:0]), 1'b1, it.final_byte);
          n_pairs++;
        end else begin
          n  = 1;
          p0 = mk_unit(acc_bits[15:0], 1'b1, it.final_byte);
        end
        clear_decoder();
      end
    end
  endtask

  // Offer one byte transaction, hold it until accepted, then queue its units
  task automatic send_byte(input byte_item_t it, input logic typed, input logic [1:0] cnt,
                           input logic [15:0] c0, input logic [15:0] c1);
    int         gap;
    int         n;
    unit_item_t p0;
    unit_item_t p1;
    gap = calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      byte_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    byte_valid <= 1'b1;
    byte_item  <= it;
    do @(posedge clk); while (byte_stall);
    n_bytes++;
    decode_byte(it, n, p0, p1);
    if (typed) begin
      if (cnt == 2'd1) begin
        unit_q.push_back(mk_unit(c0, 1'b1, it.final_byte));
      end else if (cnt == 2'd2) begin
        unit_q.push_back(mk_unit(c0, 1'b0, 1'b0));
        unit_q.push_back(mk_unit(c1, 1'b1, it.final_byte));
      end
    end else begin
      if (n > 0) unit_q.push_back(p0);
      if (n > 1) unit_q.push_back(p1);
    end
  endtask

  task automatic send_rand_byte(input logic [7:0] b);
    byte_item_t it;
    it.byte_in    = b;
    it.final_byte = ($urandom_range(0, 15) == 0);
    send_byte(it, 1'b0, 2'd0, 16'h0000, 16'h0000);
  endtask

  // One random sequence: mostly well formed, some noise and foreign continuations
  task automatic send_sequence();
    int         pick;
    int         conts;
    logic [7:0] lead;
    logic [7:0] cb;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      send_rand_byte(8'($urandom_range(0, 255)));
      return;
    end
    if (pick < 35) begin
      lead  = 8'($urandom_range(8'h00, 8'h7F));
      conts = 0;
    end else if (pick < 55) begin
      lead  = 8'($urandom_range(8'h80, 8'hDF));
      conts = 1;
    end else if (pick < 80) begin
      lead  = 8'($urandom_range(8'hE0, 8'hEF));
      conts = 2;
    end else begin
      lead  = 8'($urandom_range(8'hF0, 8'hFF));
      conts = 3;
    end
    send_rand_byte(lead);
    for (int k = 0; k < conts; k++) begin
      if ($urandom_range(0, 9) == 0) cb = 8'($urandom_range(0, 255));
      else cb = 8'h80 | 8'($urandom_range(0, 63));
      send_rand_byte(cb);
    end
  endtask

  // Hold the sender until every queued unit has come out
  task automatic drain_units();
    byte_valid <= 1'b0;
    do @(posedge clk); while (unit_q.size() != 0);
  endtask

  task automatic flag_error(input string what, input unit_item_t want, input unit_item_t got);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("ERROR at %0t: %s: expected unit %h run_end %b string_end %b,",
               $realtime, what, want.code_unit, want.run_end, want.string_end);
      $display("  got unit %h run_end %b string_end %b",
               got.code_unit, got.run_end, got.string_end);
    end
  endtask

  // Compare one accepted unit with the oldest expectation
  task automatic check_unit(input unit_item_t got);
    unit_item_t want;
    if (unit_q.size() == 0) begin
      flag_error("unexpected unit", '0, got);
    end else begin
      want = unit_q.pop_front();
      n_units++;
      if (got.code_unit !== want.code_unit || got.run_end !== want.run_end ||
          got.string_end !== want.string_end) begin
        flag_error("unit mismatch", want, got);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && unit_valid && !unit_stall) check_unit(unit_item);
  end

  // Output side: draw a stall per unit, then wait for the transaction
  initial begin : unit_sink
    int hold;
    while (rst) @(posedge clk);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 5);
      if (hold > 0) begin
        unit_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        unit_stall <= 1'b0;
      end
      do @(posedge clk); while (!unit_valid);
    end
  end

  initial begin : stimulus
    byte_item_t it;
    int         waited;
    logic       paused;
    dir_tab = '{
      {8'h00, 1'b0, 1'b1, 2'd1, 16'h0000, 16'h0000},
      {8'h7F, 1'b1, 1'b1, 2'd1, 16'h007F, 16'h0000},
      {8'h80, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},   // stray continuation as lead
      {8'hBF, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      {8'hC2, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      {8'hA9, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      {8'hEF, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      {8'hBF, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      {8'hBF, 1'b1, 1'b1, 2'd1, 16'hFFFF, 16'h0000},
      {8'hF0, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      {8'h9F, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      {8'h98, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      {8'h80, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      {8'hFF, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},   // lead above 0xF7, mask 0x07
      {8'hBF, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      {8'hBF, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      {8'hBF, 1'b0, 1'b1, 2'd2, 16'hDFBF, 16'hDFFF},
      {8'hF0, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},   // value below the plane base
      {8'h80, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      {8'h80, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      {8'h80, 1'b1, 1'b1, 2'd2, 16'hD7C0, 16'hDC00},
      {8'hE2, 1'b1, 1'b1, 2'd0, 16'h0000, 16'h0000},   // cut off on the lead
      {8'hF0, 1'b0, 1'b0, 2'd0, 16'h0000, 16'h0000},
      {8'h90, 1'b1, 1'b1, 2'd0, 16'h0000, 16'h0000},   // cut off mid sequence
      {8'h41, 1'b0, 1'b1, 2'd1, 16'h0041, 16'h0000}
    };
    clear_decoder();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    for (int r = 0; r < DirRows; r++) begin
      it.byte_in    = dir_tab[r].b;
      it.final_byte = dir_tab[r].fin;
      send_byte(it, dir_tab[r].typed, dir_tab[r].cnt, dir_tab[r].u0, dir_tab[r].u1);
    end
    drain_units();

    // Random traffic, with calm stretches and one full drain midway
    paused = 1'b0;
    while (n_bytes < ByteTarget) begin
      if ($urandom_range(0, 39) == 0) calm = ~calm;
      if (!paused && n_bytes >= ByteTarget / 2) begin
        drain_units();
        paused = 1'b1;
      end
      send_sequence();
    end
    calm = 1'b0;
    byte_valid <= 1'b0;

    // Wait out the remaining units, then let any stray units show
    waited = 0;
    while (unit_q.size() != 0 && waited < 2000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (unit_q.size() != 0) begin
      flag_error("units never delivered", unit_q[0], '0);
      $display("%0d expected units left over", unit_q.size());
    end

    $display("Covered %0d bytes, %0d UTF-16 units checked, %0d surrogate pairs,",
             n_bytes, n_units, n_pairs);
    $display("%0d cut-off sequences dropped, %0d errors", n_cut, err_cnt);
    if (err_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Hard stop well past the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/u8u16_pkg.sv
rtl/core/utf8_to_utf16_decoder.sv
test/tb_top.sv
